### rtl/core/bba_pkg.sv
// Shared constants, codes and types of the bitmap block allocator.
// Depends on nothing; the files that use it refer to it by scoped names.
package bba_pkg;

    // Capacity of the allocation map and the layout derived from it.
    localparam int MAX_BLOCKS = 4096;
    localparam int WORD_W     = 32;
    localparam int MAP_WORDS  = MAX_BLOCKS / WORD_W;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int WADDR_W    = IDX_W - BIT_W;
    localparam int WCNT_W     = WADDR_W + 1;

    // Widths of the interface fields.
    localparam int FIELD_W  = 13;
    localparam int STATUS_W = 2;

    localparam logic [FIELD_W-1:0] MAX_BLOCKS_F = FIELD_W'(MAX_BLOCKS);
    localparam logic [FIELD_W-1:0] RESET_USED   = FIELD_W'(3);
    localparam logic [WORD_W-1:0]  RESET_WORD0  = WORD_W'(7);

    // Request kinds.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERR  = 2'd2;

    // One map request: an optional read and an optional write.
    typedef struct packed {
        logic               rd_en;
        logic [WADDR_W-1:0] rd_addr;
        logic               wr_en;
        logic [WADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0]  wr_data;
    } map_req_t;

endpackage

### rtl/core/bitmap_block_allocator_top.sv
// Top level of the bitmap first-fit block allocator: request sequencer,
// used-block counter and result register. Uses bba_pkg, bba_map, bba_find.
//
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the kind (allocate
//   or free), tdata the 1-based block number to free. One result per
//   request leaves on the m_axis channel: tuser carries the status, tdata
//   the granted block and the free count after the request.
//   The block_count register is written through cfg_valid/cfg_data; a
//   transfer is always taken and should only happen while the block is idle.
//   One request is handled at a time. A free reads the word of the block,
//   then checks and clears its bit in S_FCHK and goes on to S_DONE; a
//   number out of range goes to S_DONE at once. An allocate reads the map
//   one word per cycle from word zero and stops at the first word with a
//   clear bit inside block_count, or reports full at the last word inside
//   block_count; a zero block_count is full at once. The next request is
//   taken in the first cycle a result is offered. Reset marks blocks 1 to 3
//   in use at once through per-word valid bits; no clearing pass is needed.
//   When the receiver stalls, the result waits in the output register, one
//   further request is taken and its result waits in the sequencer, and
//   then no new request is accepted.
module bitmap_block_allocator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // Requests.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,  // [12:0] block_number
    input  logic [0:0]                    s_axis_tuser,  // [0] kind
    // Results.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,  // [12:0] granted_block,
                                                         // [25:13] free_count
    output logic [bba_pkg::STATUS_W-1:0]  m_axis_tuser,  // [1:0] status
    // Configuration: block_count.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bba_pkg::FIELD_W-1:0]   cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FCHK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                      state_reg, state_next;
    logic [bba_pkg::FIELD_W-1:0]     block_count_reg;
    logic [bba_pkg::FIELD_W-1:0]     used_reg, used_next;
    logic [bba_pkg::WCNT_W-1:0]      issue_reg, issue_next;
    logic [bba_pkg::WADDR_W-1:0]     qaddr_reg, qaddr_next;
    logic                            qlive_reg, qlive_next;
    logic [bba_pkg::BIT_W-1:0]       fbit_reg, fbit_next;
    logic [bba_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [bba_pkg::FIELD_W-1:0]     res_granted_reg, res_granted_next;
    logic                            m_valid_reg, m_valid_next;
    logic [bba_pkg::STATUS_W-1:0]    m_status_reg, m_status_next;
    logic [bba_pkg::FIELD_W-1:0]     m_granted_reg, m_granted_next;
    logic [bba_pkg::FIELD_W-1:0]     m_free_reg, m_free_next;

    logic [bba_pkg::FIELD_W-1:0]     limit;
    logic [bba_pkg::WCNT_W-1:0]      lim_word;
    logic [bba_pkg::BIT_W-1:0]       lim_bits;
    logic [bba_pkg::WCNT_W-1:0]      nwords;
    logic [bba_pkg::WORD_W-1:0]      scan_mask;
    logic [bba_pkg::WORD_W-1:0]      rdata;
    logic                            hit;
    logic [bba_pkg::BIT_W-1:0]       hit_idx;
    logic [bba_pkg::FIELD_W-1:0]     num;
    logic [bba_pkg::IDX_W-1:0]       num_m1;
    logic [bba_pkg::FIELD_W-1:0]     free_count;
    logic                            s_xfer;
    bba_pkg::map_req_t               map_req;

    assign s_xfer = s_axis_tvalid && s_axis_tready;
    assign num    = s_axis_tdata[bba_pkg::FIELD_W-1:0];
    assign num_m1 = bba_pkg::IDX_W'(num - bba_pkg::FIELD_W'(1));

    // Effective limit and the number of map words it covers.
    assign limit    = (block_count_reg > bba_pkg::MAX_BLOCKS_F) ?
                      bba_pkg::MAX_BLOCKS_F : block_count_reg;
    assign lim_word = limit[bba_pkg::BIT_W +: bba_pkg::WCNT_W];
    assign lim_bits = limit[bba_pkg::BIT_W-1:0];
    assign nwords   = lim_word + bba_pkg::WCNT_W'(lim_bits != '0);

    // Eligible bits of the word being checked.
    always_comb
    begin
        if ({1'b0, qaddr_reg} < lim_word)
        begin
            scan_mask = '1;
        end
        else if ({1'b0, qaddr_reg} == lim_word)
        begin
            scan_mask = (bba_pkg::WORD_W'(1) << lim_bits) - bba_pkg::WORD_W'(1);
        end
        else
        begin
            scan_mask = '0;
        end
    end

    assign free_count = (limit > used_reg) ? (limit - used_reg) : '0;

    bba_map u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (map_req),
        .rdata (rdata)
    );

    bba_find u_find (
        .word  (rdata),
        .mask  (scan_mask),
        .found (hit),
        .idx   (hit_idx)
    );

    // Request sequencer.
    always_comb
    begin
        state_next       = state_reg;
        used_next        = used_reg;
        issue_next       = issue_reg;
        qaddr_next       = qaddr_reg;
        qlive_next       = qlive_reg;
        fbit_next        = fbit_reg;
        res_status_next  = res_status_reg;
        res_granted_next = res_granted_reg;
        m_valid_next     = m_valid_reg && !m_axis_tready;
        m_status_next    = m_status_reg;
        m_granted_next   = m_granted_reg;
        m_free_next      = m_free_reg;
        map_req          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_xfer)
                begin
                    res_granted_next = '0;
                    if (s_axis_tuser[0] == bba_pkg::KIND_ALLOC)
                    begin
                        if (nwords == '0)
                        begin
                            res_status_next = bba_pkg::ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            map_req.rd_en   = 1'b1;
                            map_req.rd_addr = '0;
                            issue_next      = bba_pkg::WCNT_W'(1);
                            qaddr_next      = '0;
                            qlive_next      = 1'b1;
                            state_next      = S_SCAN;
                        end
                    end
                    else if (num == '0 || num > limit)
                    begin
                        res_status_next = bba_pkg::ST_ERR;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        map_req.rd_en   = 1'b1;
                        map_req.rd_addr = num_m1[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
                        qaddr_next      = num_m1[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
                        fbit_next       = num_m1[bba_pkg::BIT_W-1:0];
                        state_next      = S_FCHK;
                    end
                end
            end

            S_SCAN:
            begin
                qlive_next = 1'b0;
                if (qlive_reg && hit)
                begin
                    // First clear bit found: mark it used.
                    map_req.wr_en    = 1'b1;
                    map_req.wr_addr  = qaddr_reg;
                    map_req.wr_data  = rdata | (bba_pkg::WORD_W'(1) << hit_idx);
                    used_next        = used_reg + bba_pkg::FIELD_W'(1);
                    res_status_next  = bba_pkg::ST_OK;
                    res_granted_next = bba_pkg::FIELD_W'({qaddr_reg, hit_idx})
                                       + bba_pkg::FIELD_W'(1);
                    state_next       = S_DONE;
                end
                else if (qlive_reg && ({1'b0, qaddr_reg} == nwords - bba_pkg::WCNT_W'(1)))
                begin
                    res_status_next = bba_pkg::ST_FULL;
                    state_next      = S_DONE;
                end
                else if (issue_reg < nwords)
                begin
                    // Keep one word read ahead of the check.
                    map_req.rd_en   = 1'b1;
                    map_req.rd_addr = issue_reg[bba_pkg::WADDR_W-1:0];
                    qaddr_next      = issue_reg[bba_pkg::WADDR_W-1:0];
                    qlive_next      = 1'b1;
                    issue_next      = issue_reg + bba_pkg::WCNT_W'(1);
                end
            end

            S_FCHK:
            begin
                if (!rdata[fbit_reg])
                begin
                    res_status_next = bba_pkg::ST_ERR;
                end
                else
                begin
                    map_req.wr_en   = 1'b1;
                    map_req.wr_addr = qaddr_reg;
                    map_req.wr_data = rdata & ~(bba_pkg::WORD_W'(1) << fbit_reg);
                    used_next       = (used_reg != '0) ? used_reg - bba_pkg::FIELD_W'(1)
                                                       : used_reg;
                    res_status_next = bba_pkg::ST_OK;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Hand the result over once the output register is free.
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next   = 1'b1;
                    m_status_next  = res_status_reg;
                    m_granted_next = res_granted_reg;
                    m_free_next    = free_count;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            used_reg        <= bba_pkg::RESET_USED;
            block_count_reg <= bba_pkg::MAX_BLOCKS_F;
            qlive_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            qlive_reg   <= qlive_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                block_count_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        issue_reg       <= issue_next;
        qaddr_reg       <= qaddr_next;
        fbit_reg        <= fbit_next;
        res_status_reg  <= res_status_next;
        res_granted_reg <= res_granted_next;
        m_status_reg    <= m_status_next;
        m_granted_reg   <= m_granted_next;
        m_free_reg      <= m_free_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {6'd0, m_free_reg, m_granted_reg};

    // A request in work holds off further requests.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer |=> !s_axis_tready)
        else $error("request accepted while a request was in work");

    // Only a successful allocate carries a block number.
    a_granted_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != bba_pkg::ST_OK) |-> m_granted_reg == '0)
        else $error("block number reported with a failure status");

    // A granted block and the free count lie inside the managed range.
    a_granted_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_granted_reg <= limit && m_free_reg <= limit)
        else $error("result outside the managed block range");

endmodule

### rtl/core/bba_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered and enabled by re.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/bba_map.sv
// Allocation map storage: the map RAM plus one valid bit per word, so that
// a word never written since reset reads as its reset value. Uses bba_pkg, bba_ram.
module bba_map (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bba_pkg::map_req_t          req,
    output logic [bba_pkg::WORD_W-1:0] rdata
);

    logic [bba_pkg::MAP_WORDS-1:0] valid_reg;
    logic [bba_pkg::WADDR_W-1:0]   raddr_reg;
    logic                          rvalid_reg;
    logic [bba_pkg::WORD_W-1:0]    ram_q;

    bba_ram #(
        .WIDTH (bba_pkg::WORD_W),
        .DEPTH (bba_pkg::MAP_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (req.wr_en),
        .waddr (req.wr_addr),
        .wdata (req.wr_data),
        .re    (req.rd_en),
        .raddr (req.rd_addr),
        .rdata (ram_q)
    );

    // A word becomes valid once it has been written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    // Track the address and validity of the word on the read port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raddr_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else if (req.rd_en)
        begin
            raddr_reg  <= req.rd_addr;
            rvalid_reg <= valid_reg[req.rd_addr];
        end
    end

    // Unwritten words show the reset contents of the map.
    always_comb
    begin
        if (rvalid_reg)
        begin
            rdata = ram_q;
        end
        else if (raddr_reg == '0)
        begin
            rdata = bba_pkg::RESET_WORD0;
        end
        else
        begin
            rdata = '0;
        end
    end

endmodule

### rtl/core/bba_find.sv
// Lowest-clear-bit finder for one map word, restricted by a mask of
// eligible bits. Uses bba_pkg.
module bba_find (
    input  logic [bba_pkg::WORD_W-1:0] word,
    input  logic [bba_pkg::WORD_W-1:0] mask,
    output logic                       found,
    output logic [bba_pkg::BIT_W-1:0]  idx
);

    logic [bba_pkg::WORD_W-1:0] free_bits;
    logic [bba_pkg::WORD_W-1:0] lowest;

    // Isolate the lowest eligible clear bit, then encode its position.
    always_comb
    begin
        free_bits = ~word & mask;
        lowest    = free_bits & (~free_bits + bba_pkg::WORD_W'(1));
        found     = |free_bits;
        idx       = '0;
        for (int i = 0; i < bba_pkg::WORD_W; i++)
        begin
            if (lowest[i])
            begin
                idx = idx | bba_pkg::BIT_W'(i);
            end
        end
    end

endmodule

### tb/tb_bitmap_block_allocator_top.sv
// Self-checking testbench of the bitmap first-fit block allocator.
// Depends on bba_pkg, bitmap_block_allocator_top and the files it uses.
module tb_bitmap_block_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    // One result of the allocator, field by field.
    typedef struct packed {
        logic [bba_pkg::STATUS_W-1:0] status;
        logic [bba_pkg::FIELD_W-1:0]  granted;
        logic [bba_pkg::FIELD_W-1:0]  free_count;
    } alloc_result_t;

    // Directed stimulus rows: a request or a write of block_count.
    typedef enum logic {ROW_REQ, ROW_CFG} row_op_t;

    typedef struct {
        row_op_t                     op;
        logic                        kind;
        logic [bba_pkg::FIELD_W-1:0] value;
        bit                          fixed;
        alloc_result_t               want;
    } stim_row_t;

    // Block inputs, all known from time zero.
    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic [15:0]                  s_tdata = '0;
    logic [0:0]                   s_tuser = '0;
    logic                         m_tready = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic [bba_pkg::FIELD_W-1:0]  cfg_data = '0;

    // Block outputs.
    logic                         s_axis_tready;
    logic                         m_axis_tvalid;
    logic [31:0]                  m_axis_tdata;
    logic [bba_pkg::STATUS_W-1:0] m_axis_tuser;
    logic                         cfg_ready;

    // Shadow copy of the allocator state.
    bit [bba_pkg::MAX_BLOCKS-1:0] shadow_used;
    int                           shadow_used_cnt;
    logic [bba_pkg::FIELD_W-1:0]  shadow_block_count;

    // Results still owed by the block, oldest first.
    alloc_result_t       pending_results[$];

    // Fixed expectation that travels with the request now on the bus.
    bit                  cur_fixed = 1'b0;
    alloc_result_t       cur_want = '0;

    // Traffic shaping.
    int                  src_idle_pct = 0;
    int                  snk_idle_pct = 0;
    logic                hold_go = 1'b0;

    int                  fail_cnt = 0;
    stim_row_t           dir_rows[$];

    bitmap_block_allocator_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shadow state after reset.
    initial
    begin
        shadow_used        = '0;
        shadow_used[2:0]   = 3'b111;
        shadow_used_cnt    = 3;
        shadow_block_count = bba_pkg::FIELD_W'(4096);
    end

    // Effective limit: block_count saturated to the map capacity.
    function automatic int active_limit();
        return (shadow_block_count > bba_pkg::MAX_BLOCKS) ? bba_pkg::MAX_BLOCKS
                                                          : int'(shadow_block_count);
    endfunction

    // First-fit allocate or checked free on the shadow map.
    function automatic alloc_result_t apply_request(input logic kind,
                                                    input logic [bba_pkg::FIELD_W-1:0] num);
        alloc_result_t r;
        int            lim;
        int            i;
        bit            found;
        lim       = active_limit();
        r.status  = bba_pkg::ST_OK;
        r.granted = '0;
        found     = 1'b0;
        if (kind == bba_pkg::KIND_ALLOC)
        begin
            for (i = 0; i < lim && !found; i++)
            begin
                if (!shadow_used[i])
                begin
                    shadow_used[i]  = 1'b1;
                    r.granted       = bba_pkg::FIELD_W'(i + 1);
                    shadow_used_cnt = shadow_used_cnt + 1;
                    found           = 1'b1;
                end
            end
            if (!found)
                r.status = bba_pkg::ST_FULL;
        end
        else if (num == 0 || num > lim || !shadow_used[num - 1])
        begin
            r.status = bba_pkg::ST_ERR;
        end
        else
        begin
            shadow_used[num - 1] = 1'b0;
            if (shadow_used_cnt > 0)
                shadow_used_cnt = shadow_used_cnt - 1;
        end
        r.free_count = (lim > shadow_used_cnt) ?
                       bba_pkg::FIELD_W'(lim - shadow_used_cnt) : '0;
        return r;
    endfunction

    // A block in use inside the limit, found from a random start; a random
    // in-range number when none is in use, one from 1 to 8 for a zero limit.
    function automatic logic [bba_pkg::FIELD_W-1:0] pick_used_block();
        int lim;
        int start;
        int k;
        int idx;
        lim = active_limit();
        if (lim == 0)
            return bba_pkg::FIELD_W'($urandom_range(1, 8));
        start = $urandom_range(lim - 1);
        for (k = 0; k < lim; k++)
        begin
            idx = (start + k) % lim;
            if (shadow_used[idx])
                return bba_pkg::FIELD_W'(idx + 1);
        end
        return bba_pkg::FIELD_W'(start + 1);
    endfunction

    task automatic report_fail(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Offer one request and hold it until the transfer.
    task automatic send_request(input logic kind, input logic [bba_pkg::FIELD_W-1:0] num,
                                input bit fixed, input alloc_result_t want);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= kind;
        s_tdata   <= {3'b000, num};
        cur_fixed <= fixed;
        cur_want  <= want;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Stop offering and wait until every owed result has arrived.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_block_count(input logic [bba_pkg::FIELD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Request row with an expected result typed in.
    function automatic stim_row_t row_chk(input logic kind, input int value,
                                          input logic [bba_pkg::STATUS_W-1:0] st,
                                          input int gr, input int fc);
        stim_row_t row;
        row.op              = ROW_REQ;
        row.kind            = kind;
        row.value           = bba_pkg::FIELD_W'(value);
        row.fixed           = 1'b1;
        row.want.status     = st;
        row.want.granted    = bba_pkg::FIELD_W'(gr);
        row.want.free_count = bba_pkg::FIELD_W'(fc);
        return row;
    endfunction

    // Request row checked against the predictor.
    function automatic stim_row_t row_req(input logic kind, input int value);
        stim_row_t row;
        row.op    = ROW_REQ;
        row.kind  = kind;
        row.value = bba_pkg::FIELD_W'(value);
        row.fixed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    // Write of block_count.
    function automatic stim_row_t row_cfg(input int value);
        stim_row_t row;
        row.op    = ROW_CFG;
        row.kind  = bba_pkg::KIND_ALLOC;
        row.value = bba_pkg::FIELD_W'(value);
        row.fixed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    // Receiver: random stalls, plus a long hold-off started by hold_go.
    always @(posedge clk)
    begin
        static logic hold_seen = 1'b0;
        static int   hold_left = 0;
        if (hold_go != hold_seen)
        begin
            hold_seen = hold_go;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Monitor: follow register writes and requests, check every result.
    always @(posedge clk)
    begin
        alloc_result_t got;
        alloc_result_t want;
        alloc_result_t pred;
        if (rst_n)
        begin
            // Results are checked before this edge's request is queued.
            if (m_axis_tvalid && m_tready)
            begin
                got.status     = m_axis_tuser;
                got.granted    = m_axis_tdata[12:0];
                got.free_count = m_axis_tdata[25:13];
                if (pending_results.size() == 0)
                begin
                    report_fail($sformatf("result with none owed: st=%0d gr=%0d fc=%0d",
                                          got.status, got.granted, got.free_count));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                        report_fail($sformatf(
                            "exp st=%0d gr=%0d fc=%0d, got st=%0d gr=%0d fc=%0d",
                            want.status, want.granted, want.free_count,
                            got.status, got.granted, got.free_count));
                end
            end
            if (cfg_valid && cfg_ready)
                shadow_block_count = cfg_data;
            if (s_tvalid && s_axis_tready)
            begin
                pred = apply_request(s_tuser[0], s_tdata[12:0]);
                pending_results.push_back(cur_fixed ? cur_want : pred);
            end
        end
    end

    // Stimulus: reset, directed table, then random phases.
    initial
    begin
        int                          r;
        int                          seg;
        int                          n;
        int                          lim;
        int                          pick;
        logic                        kind;
        logic [bba_pkg::FIELD_W-1:0] num;
        logic [bba_pkg::FIELD_W-1:0] bc;

        // Directed rows; block_count is 4096 after reset.
        dir_rows.push_back(row_chk(bba_pkg::KIND_ALLOC, 0, bba_pkg::ST_OK, 4, 4092));
        dir_rows.push_back(row_chk(bba_pkg::KIND_FREE, 0, bba_pkg::ST_ERR, 0, 4092));
        dir_rows.push_back(row_req(bba_pkg::KIND_FREE, 4));
        // Freeing a block that is already free.
        dir_rows.push_back(row_chk(bba_pkg::KIND_FREE, 4, bba_pkg::ST_ERR, 0, 4093));
        dir_rows.push_back(row_chk(bba_pkg::KIND_FREE, 4097, bba_pkg::ST_ERR, 0, 4093));
        dir_rows.push_back(row_chk(bba_pkg::KIND_FREE, 8191, bba_pkg::ST_ERR, 0, 4093));
        dir_rows.push_back(row_req(bba_pkg::KIND_FREE, 1));
        dir_rows.push_back(row_req(bba_pkg::KIND_ALLOC, 8191));
        dir_rows.push_back(row_chk(bba_pkg::KIND_FREE, 4096, bba_pkg::ST_ERR, 0, 4093));
        // Smallest usual limit: the map is full at once.
        dir_rows.push_back(row_cfg(3));
        dir_rows.push_back(row_chk(bba_pkg::KIND_ALLOC, 0, bba_pkg::ST_FULL, 0, 0));
        dir_rows.push_back(row_req(bba_pkg::KIND_FREE, 3));
        dir_rows.push_back(row_req(bba_pkg::KIND_ALLOC, 0));
        dir_rows.push_back(row_chk(bba_pkg::KIND_FREE, 4, bba_pkg::ST_ERR, 0, 0));
        // Zero limit: every allocate is full, every free an error.
        dir_rows.push_back(row_cfg(0));
        dir_rows.push_back(row_chk(bba_pkg::KIND_ALLOC, 0, bba_pkg::ST_FULL, 0, 0));
        dir_rows.push_back(row_chk(bba_pkg::KIND_FREE, 1, bba_pkg::ST_ERR, 0, 0));
        // Limit above capacity saturates to the map size.
        dir_rows.push_back(row_cfg(8191));
        dir_rows.push_back(row_req(bba_pkg::KIND_ALLOC, 0));
        dir_rows.push_back(row_chk(bba_pkg::KIND_FREE, 4096, bba_pkg::ST_ERR, 0, 4092));
        // Limit shrunk below blocks in use: free count stays at zero.
        dir_rows.push_back(row_cfg(2));
        dir_rows.push_back(row_chk(bba_pkg::KIND_ALLOC, 0, bba_pkg::ST_FULL, 0, 0));
        dir_rows.push_back(row_req(bba_pkg::KIND_FREE, 2));
        dir_rows.push_back(row_req(bba_pkg::KIND_ALLOC, 0));
        dir_rows.push_back(row_cfg(4096));
        dir_rows.push_back(row_req(bba_pkg::KIND_ALLOC, 0));

        // Hold reset, then release it.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling.
        for (r = 0; r < dir_rows.size(); r++)
        begin
            if (dir_rows[r].op == ROW_CFG)
            begin
                wait_drain();
                write_block_count(dir_rows[r].value);
            end
            else
            begin
                send_request(dir_rows[r].kind, dir_rows[r].value, dir_rows[r].fixed,
                             dir_rows[r].want);
            end
        end

        // Random part: 18 segments, each at its own block_count.
        for (seg = 0; seg < 18; seg++)
        begin
            if (seg == 0)
            begin
                src_idle_pct = 6;
                snk_idle_pct = 63;
            end
            else if (seg == 6)
            begin
                src_idle_pct = 63;
                snk_idle_pct = 6;
            end
            else if (seg == 12)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end

            // block_count is written only with nothing in flight.
            wait_drain();
            case (seg % 6)
                0: bc = bba_pkg::FIELD_W'(4096);
                1: bc = bba_pkg::FIELD_W'($urandom_range(3, 48));
                2: bc = bba_pkg::FIELD_W'(3);
                3: bc = bba_pkg::FIELD_W'($urandom_range(0, 8191));
                4: bc = bba_pkg::FIELD_W'($urandom_range(33, 200));
                default: bc = bba_pkg::FIELD_W'($urandom_range(0, 2));
            endcase
            write_block_count(bc);

            // Long receiver hold-off while requests keep coming.
            if (seg == 1)
                hold_go <= ~hold_go;

            for (n = 0; n < 95; n++)
            begin
                lim  = active_limit();
                kind = ($urandom_range(99) < 55) ? bba_pkg::KIND_ALLOC : bba_pkg::KIND_FREE;
                num  = bba_pkg::FIELD_W'($urandom_range(0, 8191));
                if (kind == bba_pkg::KIND_FREE)
                begin
                    pick = $urandom_range(99);
                    if (pick < 50)
                        num = pick_used_block();
                    else if (pick < 65)
                        num = bba_pkg::FIELD_W'($urandom_range(1, lim + 2));
                    else if (pick < 80)
                        num = bba_pkg::FIELD_W'(($urandom_range(2) == 0) ? 0 :
                                                lim + $urandom_range(1));
                end
                send_request(kind, num, 1'b0, '0);
            end
        end

        // Drain, let the longest scan pass, then judge.
        wait_drain();
        repeat (150) @(posedge clk);
        if (pending_results.size() != 0)
            report_fail($sformatf("%0d results never arrived", pending_results.size()));
        if (fail_cnt == 0)
        begin
            $display("bitmap_block_allocator_top verification clean");
        end
        else
        begin
            $display("bitmap_block_allocator_top verification failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #15_000_000;
        $display("bitmap_block_allocator_top verification failed");
        $finish;
    end

endmodule

### bitmap_block_allocator_top.f
rtl/core/bba_pkg.sv
rtl/core/bba_ram.sv
rtl/core/bba_map.sv
rtl/core/bba_find.sv
rtl/core/bitmap_block_allocator_top.sv
tb/tb_bitmap_block_allocator_top.sv
